// ===== hw/rtl/fbc_pkg.sv =====
// fbc_pkg: shared types, constants and the crc-16 byte update for the frame builder
// used by every module of the frame builder except fbc_checker; no dependencies

package fbc_pkg;

    localparam int unsigned MAX_BEATS = 10;
    localparam int unsigned HDR_BEATS = 8;
    localparam int unsigned COUNT_W   = $clog2(MAX_BEATS + 1);
    localparam int unsigned IN_DATA_W = 48;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [COUNT_W-1:0] CNT_HDR      = COUNT_W'(HDR_BEATS);
    localparam logic [COUNT_W-1:0] CNT_HDR_CRC  = COUNT_W'(HDR_BEATS + 2);
    localparam logic [COUNT_W-1:0] CNT_PAY      = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] CNT_PAY_CRC  = COUNT_W'(3);

    typedef enum logic [1:0] {
        REG_SYNC_FIRST     = 2'd0,
        REG_SYNC_SECOND    = 2'd1,
        REG_FORMAT_VERSION = 2'd2
    } reg_idx_t;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_PAYLOAD = 1'b1
    } opcode_t;

    typedef logic [MAX_BEATS-1:0][7:0] frame_bytes_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] format_version;
    } cfg_t;

    typedef struct packed {
        logic               load;
        frame_bytes_t       bytes;
        logic [COUNT_W-1:0] count;
        logic               last;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/frame_builder_crc16_core.sv =====
// frame_builder_crc16_core: top level of the frame builder with crc-16/ccitt-false
// depends on fbc_pkg, fbc_regs, fbc_framer, fbc_serializer
//
//   channel   | direction | beat content
//   ----------+-----------+-----------------------------------------------------
//   s_axis    | in        | one start item (tuser 0) or one payload byte (tuser 1)
//   m_axis    | out       | one frame byte, tlast on the final crc byte
//   apb       | in/out    | sync_first @0x0, sync_second @0x4, format_version @0x8
//
// an item waits in the input register until the result register is free, then loads it
// start item: 8 output beats (10 with zero length); payload byte: 1 or 3, none if no frame
// output sets the rate: one beat per cycle unless stalled; mid-frame payload: 1 item/cycle
// reset clears the frame state (crc 0xffff, no open frame) and empties both registers
// a stalled output holds its beat; the input register takes one item, then waits until it frees

module frame_builder_crc16_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fbc_pkg::IN_DATA_W-1:0] s_tdata,  // message_type, sequence_number,
                                                    // length_bytes, payload_byte
    input  logic                          s_tuser,  // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // out_byte
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    fbc_pkg::cfg_t    cfg;
    fbc_pkg::result_t result;
    logic             res_free;

    fbc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fbc_framer u_framer (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .res_free (res_free),
        .result   (result)
    );

    fbc_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .res_free (res_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hw/rtl/fbc_regs.sv =====
// fbc_regs: apb-style configuration registers (sync bytes and format version)
// depends on fbc_pkg

module fbc_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output fbc_pkg::cfg_t     cfg
);

    fbc_pkg::reg_idx_t idx;
    logic              wr;
    fbc_pkg::cfg_t     cfg_reg;
    fbc_pkg::cfg_t     cfg_next;

    assign idx    = fbc_pkg::reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        case (idx)
            fbc_pkg::REG_SYNC_FIRST:
            begin
                prdata[7:0] = cfg_reg.sync_first;
                if (wr)
                    cfg_next.sync_first = pwdata[7:0];
            end
            fbc_pkg::REG_SYNC_SECOND:
            begin
                prdata[7:0] = cfg_reg.sync_second;
                if (wr)
                    cfg_next.sync_second = pwdata[7:0];
            end
            fbc_pkg::REG_FORMAT_VERSION:
            begin
                prdata[7:0] = cfg_reg.format_version;
                if (wr)
                    cfg_next.format_version = pwdata[7:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

// ===== hw/rtl/fbc_framer.sv =====
// fbc_framer: input register, frame state (crc, bytes left, open flag) and result build
// depends on fbc_pkg

module fbc_framer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fbc_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    input  fbc_pkg::cfg_t                     cfg,
    input  logic                              res_free,
    output fbc_pkg::result_t                  result
);

    logic        in_load;
    logic        take;
    logic        in_valid_reg;
    logic        in_valid_next;

    fbc_pkg::opcode_t op_reg;
    logic [7:0]  type_reg;
    logic [15:0] seq_reg;
    logic [15:0] len_reg;
    logic [7:0]  pay_reg;
    logic [15:0] hcrc_reg;
    logic [15:0] hcrc_next;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic        open_reg;
    logic        open_next;

    assign in_load  = s_tvalid && s_tready;
    assign take     = in_valid_reg && res_free;
    assign s_tready = !in_valid_reg || take;

    // header crc over version, type and sequence number, ahead of the length bytes
    always_comb
    begin
        hcrc_next = fbc_pkg::crc16_byte(fbc_pkg::CRC_INIT, cfg.format_version);
        hcrc_next = fbc_pkg::crc16_byte(hcrc_next, s_tdata[7:0]);
        hcrc_next = fbc_pkg::crc16_byte(hcrc_next, s_tdata[23:16]);
        hcrc_next = fbc_pkg::crc16_byte(hcrc_next, s_tdata[15:8]);
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_load)
            in_valid_next = 1'b1;
        else if (take)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        logic [15:0] c;
        logic [15:0] rem_dec;

        c         = '0;
        rem_dec   = rem_reg - 16'd1;
        crc_next  = crc_reg;
        rem_next  = rem_reg;
        open_next = open_reg;
        result    = '0;

        if (take)
        begin
            result.load = 1'b1;
            case (op_reg)
                fbc_pkg::OP_START:
                begin
                    c = fbc_pkg::crc16_byte(hcrc_reg, len_reg[15:8]);
                    c = fbc_pkg::crc16_byte(c, len_reg[7:0]);
                    result.bytes[0] = cfg.sync_first;
                    result.bytes[1] = cfg.sync_second;
                    result.bytes[2] = cfg.format_version;
                    result.bytes[3] = type_reg;
                    result.bytes[4] = seq_reg[15:8];
                    result.bytes[5] = seq_reg[7:0];
                    result.bytes[6] = len_reg[15:8];
                    result.bytes[7] = len_reg[7:0];
                    result.bytes[8] = c[15:8];
                    result.bytes[9] = c[7:0];
                    crc_next  = c;
                    rem_next  = len_reg;
                    open_next = (len_reg != 16'd0);
                    if (len_reg == 16'd0)
                    begin
                        result.count = fbc_pkg::CNT_HDR_CRC;
                        result.last  = 1'b1;
                    end
                    else
                    begin
                        result.count = fbc_pkg::CNT_HDR;
                    end
                end
                fbc_pkg::OP_PAYLOAD:
                begin
                    if (open_reg)
                    begin
                        c = fbc_pkg::crc16_byte(crc_reg, pay_reg);
                        result.bytes[0] = pay_reg;
                        result.bytes[1] = c[15:8];
                        result.bytes[2] = c[7:0];
                        crc_next = c;
                        rem_next = rem_dec;
                        if (rem_dec == 16'd0)
                        begin
                            open_next    = 1'b0;
                            result.count = fbc_pkg::CNT_PAY_CRC;
                            result.last  = 1'b1;
                        end
                        else
                        begin
                            result.count = fbc_pkg::CNT_PAY;
                        end
                    end
                end
                default:
                begin
                    result.count = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            crc_reg      <= fbc_pkg::CRC_INIT;
            rem_reg      <= '0;
            open_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            crc_reg      <= crc_next;
            rem_reg      <= rem_next;
            open_reg     <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            op_reg   <= fbc_pkg::opcode_t'(s_tuser);
            type_reg <= s_tdata[7:0];
            seq_reg  <= s_tdata[23:8];
            len_reg  <= s_tdata[39:24];
            pay_reg  <= s_tdata[47:40];
            hcrc_reg <= hcrc_next;
        end
    end

endmodule

// ===== hw/rtl/fbc_serializer.sv =====
// fbc_serializer: result register that emits the bytes of one item, one beat per cycle
// while m_tready is high; depends on fbc_pkg

module fbc_serializer (
    input  logic             clk,
    input  logic             rst_n,
    input  fbc_pkg::result_t result,
    output logic             res_free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    fbc_pkg::frame_bytes_t               buf_reg;
    fbc_pkg::frame_bytes_t               buf_next;
    logic [fbc_pkg::COUNT_W-1:0]         left_reg;
    logic [fbc_pkg::COUNT_W-1:0]         left_next;
    logic                                end_reg;
    logic                                end_next;
    logic                                beat;
    logic                                on_last;

    assign on_last  = (left_reg == fbc_pkg::COUNT_W'(1));
    assign m_tvalid = (left_reg != '0);
    assign m_tdata  = buf_reg[0];
    assign m_tlast  = end_reg && on_last;
    assign beat     = m_tvalid && m_tready;
    assign res_free = !m_tvalid || (on_last && m_tready);

    always_comb
    begin
        buf_next  = buf_reg;
        left_next = left_reg;
        end_next  = end_reg;
        if (result.load)
        begin
            buf_next  = result.bytes;
            left_next = result.count;
            end_next  = result.last;
        end
        else if (beat)
        begin
            buf_next  = {8'h00, buf_reg[fbc_pkg::MAX_BEATS-1:1]};
            left_next = left_reg - fbc_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            end_reg  <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            end_reg  <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

// ===== hw/rtl/fbc_checker.sv =====
// fbc_checker: port-level assertions for the frame builder, bound to the top level
// depends on frame_builder_crc16_core

module fbc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [7:0]                    m_tdata,
    input logic                          m_tlast,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [3:0]                    paddr,
    input logic [31:0]                   pwdata,
    input logic [31:0]                   prdata
);

    logic s_beat;

    assign s_beat = s_tvalid && s_tready;

    // a stalled output beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat withdrawn under stall");

    // a stalled output beat keeps its content
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed under stall");

    // with nothing taken in and nothing pending, no beat appears
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid && !s_beat) ##1 (!m_tvalid && !s_beat) |=> !m_tvalid)
        else $error("output beat with no input item");

    // a written sync_first byte reads back
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr == 4'h0) ##1 (paddr == 4'h0)
        |-> prdata[7:0] == $past(pwdata[7:0]))
        else $error("configuration readback mismatch");

endmodule

bind frame_builder_crc16_core fbc_checker u_fbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
